// ===== hdl/ypr_pkg.sv =====
// ============================================================================
// ypr_pkg
// Shared types, codes and the CRC-16/XMODEM byte update for the YMODEM
// packet receiver.
// ============================================================================
package ypr_pkg;

	// input kinds
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_TICK    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// protocol bytes
	localparam logic [7:0] BYTE_SOH = 8'h01;
	localparam logic [7:0] BYTE_STX = 8'h02;
	localparam logic [7:0] BYTE_EOT = 8'h04;
	localparam logic [7:0] BYTE_ACK = 8'h06;
	localparam logic [7:0] BYTE_NAK = 8'h15;
	localparam logic [7:0] BYTE_REQ = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	// packet framing: block, complement, data, crc high, crc low
	localparam logic [10:0] SMALL_END = 11'd130;   // 128 data bytes + 2
	localparam logic [10:0] LARGE_END = 11'd1026;  // 1024 data bytes + 2

	// event codes
	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_HEADER = 3'd1;
	localparam logic [2:0] EV_DATA   = 3'd2;
	localparam logic [2:0] EV_BAD    = 3'd3;
	localparam logic [2:0] EV_ERROR  = 3'd4;
	localparam logic [2:0] EV_END    = 3'd5;

	// reported mode codes
	localparam logic [2:0] MC_WAIT_HDR  = 3'd0;
	localparam logic [2:0] MC_WAIT_PKT  = 3'd1;
	localparam logic [2:0] MC_IN_PKT    = 3'd2;
	localparam logic [2:0] MC_AFTER_EOT = 3'd3;
	localparam logic [2:0] MC_ENDED     = 3'd4;
	localparam logic [2:0] MC_ERROR     = 3'd5;

	// register indexes
	localparam logic [1:0] REG_RETRY   = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_ERRLIM  = 2'd2;

	localparam logic [23:0] RETRY_RST   = 24'd1000000;
	localparam logic [23:0] TIMEOUT_RST = 24'd10000000;
	localparam logic [3:0]  ERRLIM_RST  = 4'd10;

	// result queue
	localparam int OUT_DEPTH = 4;
	localparam int PTR_W     = $clog2(OUT_DEPTH);
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

	typedef enum logic [5:0] {
		M_WAIT_HDR  = 6'b000001,
		M_WAIT_PKT  = 6'b000010,
		M_IN_PKT    = 6'b000100,
		M_AFTER_EOT = 6'b001000,
		M_ENDED     = 6'b010000,
		M_ERROR     = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [23:0] retry_interval;
		logic [23:0] packet_timeout;
		logic [3:0]  error_limit;
	} cfg_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [9:0] payload_index;
		logic [2:0] event_code;
		logic [2:0] mode_now;
		logic       last;
	} res_t;

	typedef struct packed {
		logic vld;
		logic two;
		res_t r0;
		res_t r1;
	} push_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		unique case (m)
			M_WAIT_HDR:  c = MC_WAIT_HDR;
			M_WAIT_PKT:  c = MC_WAIT_PKT;
			M_IN_PKT:    c = MC_IN_PKT;
			M_AFTER_EOT: c = MC_AFTER_EOT;
			M_ENDED:     c = MC_ENDED;
			M_ERROR:     c = MC_ERROR;
			default:     c = MC_ERROR;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/ypr_core.sv =====
// ============================================================================
// ypr_core
// Input register and protocol state; while the result queue has room, one
// item is decoded per cycle into one or two result records.
// ============================================================================
module ypr_core
	import ypr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] rx_byte,
	input  logic       room,
	output push_t      push
);

	logic        vld_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  byte_s1;
	logic        adv;

	mode_t       mode_q, mode_d;
	logic        hdr_pkt_q, hdr_pkt_d;
	logic        large_q, large_d;
	logic [10:0] pos_q, pos_d;
	logic [7:0]  exp_blk_q, exp_blk_d;
	logic [7:0]  got_blk_q, got_blk_d;
	logic        hdr_bad_q, hdr_bad_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] rcrc_q, rcrc_d;
	logic [3:0]  bad_cnt_q, bad_cnt_d;
	logic [23:0] req_tmr_q, req_tmr_d;
	logic        req_en_q, req_en_d;
	logic [23:0] dl_tmr_q, dl_tmr_d;

	logic        start_pkt, start_hdr, start_large, two;
	logic [10:0] end_pos;
	logic [15:0] rcrc_full;
	logic [10:0] data_idx;
	logic        ok;
	res_t        r0, r1;

	assign adv      = vld_s1 & room;
	assign in_ready = ~vld_s1 | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			byte_s1 <= rx_byte;
		end
	end

	assign end_pos   = large_q ? LARGE_END : SMALL_END;
	assign rcrc_full = {rcrc_q[15:8], byte_s1};
	assign data_idx  = pos_q - 11'd2;
	assign ok        = ~hdr_bad_q && (rcrc_full == crc_q) && (hdr_pkt_q || got_blk_q == exp_blk_q);

	always_comb begin
		mode_d      = mode_q;
		hdr_pkt_d   = hdr_pkt_q;
		large_d     = large_q;
		pos_d       = pos_q;
		exp_blk_d   = exp_blk_q;
		got_blk_d   = got_blk_q;
		hdr_bad_d   = hdr_bad_q;
		crc_d       = crc_q;
		rcrc_d      = rcrc_q;
		bad_cnt_d   = bad_cnt_q;
		req_tmr_d   = req_tmr_q;
		req_en_d    = req_en_q;
		dl_tmr_d    = dl_tmr_q;
		start_pkt   = 1'b0;
		start_hdr   = 1'b0;
		start_large = 1'b0;
		two         = 1'b0;
		r0          = '0;
		r1          = '0;

		unique case (kind_s1)
			KIND_RESTART: begin
				mode_d    = M_WAIT_HDR;
				hdr_pkt_d = 1'b1;
				large_d   = 1'b0;
				pos_d     = '0;
				got_blk_d = '0;
				hdr_bad_d = 1'b0;
				crc_d     = '0;
				rcrc_d    = '0;
				bad_cnt_d = '0;
				req_tmr_d = '0;
				req_en_d  = 1'b1;
				dl_tmr_d  = '0;
			end
			KIND_TICK: begin
				if ((mode_q == M_WAIT_HDR || mode_q == M_WAIT_PKT) && req_en_q) begin
					if (req_tmr_q == '0) begin
						r0.tx_valid = 1'b1;
						r0.tx_byte  = BYTE_REQ;
						req_tmr_d   = cfg.retry_interval;
					end else begin
						req_tmr_d = req_tmr_q - 24'd1;
					end
				end else if (mode_q == M_IN_PKT || mode_q == M_AFTER_EOT) begin
					if (dl_tmr_q == '0) begin
						r0.event_code = EV_ERROR;
						mode_d        = M_ERROR;
					end else begin
						dl_tmr_d = dl_tmr_q - 24'd1;
					end
				end
			end
			KIND_BYTE: begin
				unique case (mode_q)
					M_WAIT_HDR: begin
						if (byte_s1 == BYTE_SOH) begin
							start_pkt = 1'b1;
							start_hdr = 1'b1;
						end
					end
					M_WAIT_PKT: begin
						if (byte_s1 == BYTE_SOH) begin
							start_pkt = 1'b1;
						end else if (byte_s1 == BYTE_STX) begin
							start_pkt   = 1'b1;
							start_large = 1'b1;
						end else if (byte_s1 == BYTE_EOT) begin
							r0.tx_valid = 1'b1;
							r0.tx_byte  = BYTE_NAK;
							req_en_d    = 1'b0;
							dl_tmr_d    = cfg.packet_timeout;
							mode_d      = M_AFTER_EOT;
						end
					end
					M_AFTER_EOT: begin
						if (byte_s1 == BYTE_EOT) begin
							r0.tx_valid   = 1'b1;
							r0.tx_byte    = BYTE_ACK;
							r0.event_code = EV_END;
							mode_d        = M_ENDED;
						end
					end
					M_IN_PKT: begin
						pos_d = pos_q + 11'd1;
						if (pos_q == 11'd0) begin
							got_blk_d = byte_s1;
						end else if (pos_q == 11'd1) begin
							hdr_bad_d = (byte_s1 != ~got_blk_q);
						end else if (pos_q < end_pos) begin
							crc_d            = crc_byte(crc_q, byte_s1);
							r0.payload_valid = 1'b1;
							r0.payload_byte  = byte_s1;
							r0.payload_index = data_idx[9:0];
						end else if (pos_q == end_pos) begin
							rcrc_d = {byte_s1, 8'h00};
						end else begin
							rcrc_d      = rcrc_full;
							pos_d       = '0;
							r0.tx_valid = 1'b1;
							if (ok) begin
								r0.tx_byte = BYTE_ACK;
								mode_d     = M_WAIT_PKT;
								if (hdr_pkt_q) begin
									r0.event_code = EV_HEADER;
									exp_blk_d     = 8'd1;
									req_en_d      = 1'b1;
									req_tmr_d     = '0;
								end else begin
									r0.event_code = EV_DATA;
									exp_blk_d     = exp_blk_q + 8'd1;
								end
							end else begin
								r0.tx_byte    = BYTE_NAK;
								r0.event_code = EV_BAD;
								if (bad_cnt_q != 4'hF) begin
									bad_cnt_d = bad_cnt_q + 4'd1;
								end
								mode_d = hdr_pkt_q ? M_WAIT_HDR : M_WAIT_PKT;
								if (bad_cnt_q > cfg.error_limit) begin
									r1.event_code = EV_ERROR;
									mode_d        = M_ERROR;
									two           = 1'b1;
								end
							end
						end
					end
					M_ENDED, M_ERROR: begin
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		// open a new packet frame
		if (start_pkt) begin
			mode_d    = M_IN_PKT;
			hdr_pkt_d = start_hdr;
			large_d   = start_large;
			pos_d     = '0;
			crc_d     = '0;
			rcrc_d    = '0;
			got_blk_d = '0;
			hdr_bad_d = 1'b0;
			req_en_d  = 1'b0;
			dl_tmr_d  = cfg.packet_timeout;
		end

		r0.mode_now = mode_code(mode_d);
		r1.mode_now = mode_code(mode_d);
		r0.last     = ~two;
		r1.last     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_WAIT_HDR;
			hdr_pkt_q <= 1'b1;
			large_q   <= 1'b0;
			pos_q     <= '0;
			exp_blk_q <= '0;
			got_blk_q <= '0;
			hdr_bad_q <= 1'b0;
			crc_q     <= '0;
			rcrc_q    <= '0;
			bad_cnt_q <= '0;
			req_tmr_q <= '0;
			req_en_q  <= 1'b1;
			dl_tmr_q  <= '0;
		end else if (adv) begin
			mode_q    <= mode_d;
			hdr_pkt_q <= hdr_pkt_d;
			large_q   <= large_d;
			pos_q     <= pos_d;
			exp_blk_q <= exp_blk_d;
			got_blk_q <= got_blk_d;
			hdr_bad_q <= hdr_bad_d;
			crc_q     <= crc_d;
			rcrc_q    <= rcrc_d;
			bad_cnt_q <= bad_cnt_d;
			req_tmr_q <= req_tmr_d;
			req_en_q  <= req_en_d;
			dl_tmr_q  <= dl_tmr_d;
		end
	end

	assign push.vld = adv;
	assign push.two = two;
	assign push.r0  = r0;
	assign push.r1  = r1;

endmodule

// ===== hdl/ypr_out_fifo.sv =====
// ============================================================================
// ypr_out_fifo
// Small result queue; takes one or two records per cycle, hands out one beat.
// ============================================================================
module ypr_out_fifo
	import ypr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  head
);

	res_t             mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wr_ptr_nx;
	logic             pop;
	logic [CNT_W-1:0] n_in;

	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
	assign pop       = out_valid & out_ready;
	assign n_in      = push.vld ? (push.two ? CNT_W'(2) : CNT_W'(1)) : CNT_W'(0);
	assign room      = cnt_q <= CNT_W'(OUT_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.vld) begin
			mem_q[wr_ptr_q] <= push.r0;
			if (push.two) begin
				mem_q[wr_ptr_nx] <= push.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_in);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + n_in - CNT_W'(pop);
		end
	end

endmodule

// ===== hdl/ymodem_packet_receiver_unit.sv =====
// ============================================================================
// ymodem_packet_receiver_unit
// YMODEM-CRC receiver: frames SOH/STX packets, streams payload, answers
// ACK/NAK/'C' and reports protocol events.
// ============================================================================
// One input beat (a received byte, a timer tick or a restart) is taken per
// clock while the result queue has room. Each beat lands in an input
// register, is decoded combinationally against the protocol state (the
// CRC-16/XMODEM byte update is eight XOR steps of logic) and leaves one
// result record, or two when a bad packet arrives with the bad count already
// above error_limit, in a four-entry result queue. Results leave at one beat
// per cycle while out_ready is high; an item with two results takes two
// output beats, and the input stalls only while the queue holds more than
// two records. Registers sit at byte addresses 0 (retry_interval), 4
// (packet_timeout) and 8 (error_limit) and take effect on the next item;
// write them only when the block is idle.
// ============================================================================
module ymodem_packet_receiver_unit
	import ypr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic [9:0]  payload_index,
	output logic [2:0]  event_code,
	output logic [2:0]  mode_now,
	output logic        last
);

	cfg_t  cfg_q;
	logic  cfg_wr;
	logic  room;
	push_t push;
	res_t  head;

	// Register file: write in the access phase, never wait.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_interval <= RETRY_RST;
			cfg_q.packet_timeout <= TIMEOUT_RST;
			cfg_q.error_limit    <= ERRLIM_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_RETRY:   cfg_q.retry_interval <= pwdata[23:0];
				REG_TIMEOUT: cfg_q.packet_timeout <= pwdata[23:0];
				REG_ERRLIM:  cfg_q.error_limit    <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RETRY:   prdata = {8'h00, cfg_q.retry_interval};
			REG_TIMEOUT: prdata = {8'h00, cfg_q.packet_timeout};
			REG_ERRLIM:  prdata = {28'h0, cfg_q.error_limit};
			default:     prdata = '0;
		endcase
	end

	// Decode one beat per cycle; hold the input while the queue is nearly full.
	ypr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.rx_byte  (rx_byte),
		.room     (room),
		.push     (push)
	);

	// Queue results so a stalled consumer does not stop the decoder at once.
	ypr_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign tx_valid      = head.tx_valid;
	assign tx_byte       = head.tx_byte;
	assign payload_valid = head.payload_valid;
	assign payload_byte  = head.payload_byte;
	assign payload_index = head.payload_index;
	assign event_code    = head.event_code;
	assign mode_now      = head.mode_now;
	assign last          = head.last;

endmodule
